// ===== src/lgsepc_pkg.sv =====
`default_nettype none

package lgsepc_pkg;

  localparam int DATA_W           = 32;
  localparam int ANGLE_W          = 31;
  localparam int CFG_IDX_W        = 4;
  localparam int CORDIC_STEPS_DEF = 28;
  localparam int ATAN_IDX_W       = 5;
  localparam int DIV_NUM_W        = 64;
  localparam int PROD_W           = 2 * DATA_W;

  localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_RADIUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ELONG_SCALE   = CFG_IDX_W'(1);

  localparam logic [DATA_W-1:0]        RADIUS_RST   = 32'd1310720;
  localparam logic [DATA_W-1:0]        SCALE_RST    = 32'd16777216;
  localparam logic [DATA_W-1:0]        INV_GAIN_Q32 = 32'd2608131496;
  localparam logic signed [DATA_W-1:0] PI_Q28       = 32'sd843314857;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQSUM,
    ST_SQRT,
    ST_MAGCHK,
    ST_MULX,
    ST_DIVX_GO,
    ST_DIVX_WAIT,
    ST_MULY,
    ST_DIVY_GO,
    ST_DIVY_WAIT,
    ST_OFS,
    ST_ROT,
    ST_MAG0,
    ST_MAG1,
    ST_MAG2,
    ST_EL0,
    ST_EL1,
    ST_EL2,
    ST_PUT
  } state_t;

  // atan(2^-i) in Q4.28, rounded to nearest
  function automatic logic [DATA_W-1:0] atan_q28(input logic [ATAN_IDX_W-1:0] idx);
    logic [DATA_W-1:0] v;
    unique case (idx)
      5'd0:    v = 32'd210828714;
      5'd1:    v = 32'd124459457;
      5'd2:    v = 32'd65760959;
      5'd3:    v = 32'd33381290;
      5'd4:    v = 32'd16755422;
      5'd5:    v = 32'd8385879;
      5'd6:    v = 32'd4193963;
      5'd7:    v = 32'd2097109;
      5'd8:    v = 32'd1048571;
      5'd9:    v = 32'd524287;
      5'd10:   v = 32'd262144;
      5'd11:   v = 32'd131072;
      5'd12:   v = 32'd65536;
      5'd13:   v = 32'd32768;
      5'd14:   v = 32'd16384;
      5'd15:   v = 32'd8192;
      5'd16:   v = 32'd4096;
      5'd17:   v = 32'd2048;
      5'd18:   v = 32'd1024;
      5'd19:   v = 32'd512;
      5'd20:   v = 32'd256;
      5'd21:   v = 32'd128;
      5'd22:   v = 32'd64;
      5'd23:   v = 32'd32;
      5'd24:   v = 32'd16;
      5'd25:   v = 32'd8;
      5'd26:   v = 32'd4;
      5'd27:   v = 32'd2;
      5'd28:   v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/lgsepc_div.sv =====
`default_nettype none

module lgsepc_div
  import lgsepc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] dividend,
  input  logic [DATA_W-1:0]    divisor,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DATA_W-1:0]    rem_r;
  logic [DATA_W-1:0]    den_r;

  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      diff;
  logic                 ge;
  logic [DATA_W-1:0]    rem_nxt;
  logic [DIV_NUM_W-1:0] num_nxt;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_r, num_r[DIV_NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
    num_nxt = {num_r[DIV_NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

`default_nettype wire

// ===== src/lgs_elongation_polar_converter_unit.sv =====
`default_nettype none

// Channel  Dir  Handshake             Payload
// in_      in   in_valid / in_stall   in_mode, in_coord_x, in_coord_y
// out_     out  out_valid / out_stall out_elongation, out_angle
// cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Subaperture request: run by the CORDIC loop, one rotation per cycle on a
// shared shift/add unit. Direction request: run by the 32-step square root
// and two 64-step divisions; a zero direction clears the launch point after
// the square root. Reset is synchronous: launch point cleared, registers at
// defaults. in_stall stays high while a request is in work; a finished
// result sits in the output register, so a new request is taken while it
// waits.

module lgs_elongation_polar_converter_unit
  import lgsepc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_mode,
  input  logic signed [DATA_W-1:0]  in_coord_x,
  input  logic signed [DATA_W-1:0]  in_coord_y,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DATA_W-1:0]         out_elongation,
  output logic signed [ANGLE_W-1:0] out_angle,

  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [DATA_W-1:0]         cfg_data
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int OFS_W  = DATA_W + 1;
  localparam int GUARD  = 16;
  localparam int CW     = 52;
  localparam int MAG_W  = 37;
  localparam logic signed [ANGLE_W-1:0] PI_ANG = ANGLE_W'(PI_Q28);
  localparam logic [PROD_W-1:0] SQRT_BIT0 = PROD_W'(1) << (PROD_W - 2);

  state_t                    state_r, state_nxt;

  logic [DATA_W-1:0]         radius_r;
  logic [DATA_W-1:0]         scale_r;
  logic signed [DATA_W-1:0]  launch_x_r;
  logic signed [DATA_W-1:0]  launch_y_r;
  logic                      out_valid_r;
  logic [DATA_W-1:0]         out_el_r;
  logic signed [ANGLE_W-1:0] out_ang_r;

  logic signed [DATA_W-1:0]  cx_r;
  logic signed [DATA_W-1:0]  cy_r;
  logic [PROD_W-1:0]         prod_r;
  logic [PROD_W-1:0]         acc_r;
  logic [PROD_W-1:0]         rt_r;
  logic [PROD_W-1:0]         bit_r;
  logic signed [CW-1:0]      x_r;
  logic signed [CW-1:0]      y_r;
  logic signed [DATA_W-1:0]  z_r;
  logic [STEP_W-1:0]         step_r;
  logic [MAG_W-1:0]          mag_r;
  logic [DATA_W-1:0]         res_el_r;
  logic signed [ANGLE_W-1:0] res_ang_r;

  logic [DATA_W-1:0]         mul_a;
  logic [DATA_W-1:0]         mul_b;
  logic [PROD_W-1:0]         prod_nxt;
  logic [DATA_W-1:0]         abs_cx;
  logic [DATA_W-1:0]         abs_cy;
  logic [PROD_W-1:0]         sqrt_trial;
  logic signed [OFS_W-1:0]   dx;
  logic signed [OFS_W-1:0]   dy;
  logic signed [CW-1:0]      x_ofs;
  logic signed [CW-1:0]      y_ofs;
  logic [ATAN_IDX_W-1:0]     step_idx;
  logic signed [CW-1:0]      xs;
  logic signed [CW-1:0]      ys;
  logic signed [DATA_W-1:0]  atan_v;
  logic [PROD_W-1:0]         hi_sum;
  logic signed [DATA_W-1:0]  z_clamp;
  logic [ANGLE_W-1:0]        q_sat;
  logic signed [DATA_W-1:0]  q_mag;
  logic                      coord_neg;
  logic signed [DATA_W-1:0]  launch_val;

  logic                      div_start;
  logic                      div_done;
  logic [DIV_NUM_W-1:0]      div_quo;
  logic                      launch_clr;
  logic                      launch_wr_x;
  logic                      launch_wr_y;
  logic                      out_free;
  logic                      out_load;

  lgsepc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (rt_r[DATA_W-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    abs_cx     = cx_r[DATA_W-1] ? (~cx_r + 1'b1) : cx_r;
    abs_cy     = cy_r[DATA_W-1] ? (~cy_r + 1'b1) : cy_r;
    sqrt_trial = rt_r + bit_r;

    dx    = OFS_W'(cx_r) - OFS_W'(launch_x_r);
    dy    = OFS_W'(cy_r) - OFS_W'(launch_y_r);
    x_ofs = {{(CW - OFS_W - GUARD){dx[OFS_W-1]}}, dx, {GUARD{1'b0}}};
    y_ofs = {{(CW - OFS_W - GUARD){dy[OFS_W-1]}}, dy, {GUARD{1'b0}}};

    step_idx = ATAN_IDX_W'(step_r);
    xs       = x_r >>> step_idx;
    ys       = y_r >>> step_idx;
    atan_v   = $signed(atan_q28(step_idx));

    hi_sum = prod_r + {{DATA_W{1'b0}}, acc_r[PROD_W-1:DATA_W]};

    if (z_r > PI_Q28) begin
      z_clamp = PI_Q28;
    end else if (z_r < -PI_Q28) begin
      z_clamp = -PI_Q28;
    end else begin
      z_clamp = z_r;
    end

    q_sat      = (|div_quo[DIV_NUM_W-1:ANGLE_W]) ? {ANGLE_W{1'b1}} : div_quo[ANGLE_W-1:0];
    q_mag      = $signed({1'b0, q_sat});
    coord_neg  = (state_r == ST_DIVY_WAIT) ? cy_r[DATA_W-1] : cx_r[DATA_W-1];
    launch_val = coord_neg ? -q_mag : q_mag;
  end

  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    launch_clr  = 1'b0;
    launch_wr_x = 1'b0;
    launch_wr_y = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = in_mode ? ST_OFS : ST_SQX;
      end
      ST_SQX: begin
        mul_a     = abs_cx;
        mul_b     = abs_cx;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        mul_a     = abs_cy;
        mul_b     = abs_cy;
        state_nxt = ST_SQSUM;
      end
      ST_SQSUM: state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (bit_r[0]) state_nxt = ST_MAGCHK;
      end
      ST_MAGCHK: begin
        if (rt_r == '0) begin
          launch_clr = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_MULX;
        end
      end
      ST_MULX: begin
        mul_a     = abs_cx;
        mul_b     = radius_r;
        state_nxt = ST_DIVX_GO;
      end
      ST_DIVX_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIVX_WAIT;
      end
      ST_DIVX_WAIT: begin
        if (div_done) begin
          launch_wr_x = 1'b1;
          state_nxt   = ST_MULY;
        end
      end
      ST_MULY: begin
        mul_a     = abs_cy;
        mul_b     = radius_r;
        state_nxt = ST_DIVY_GO;
      end
      ST_DIVY_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIVY_WAIT;
      end
      ST_DIVY_WAIT: begin
        if (div_done) begin
          launch_wr_y = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_OFS: begin
        state_nxt = (dx == '0 && dy == '0) ? ST_PUT : ST_ROT;
      end
      ST_ROT: begin
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) state_nxt = ST_MAG0;
      end
      ST_MAG0: begin
        mul_a     = x_r[DATA_W-1:0];
        mul_b     = INV_GAIN_Q32;
        state_nxt = ST_MAG1;
      end
      ST_MAG1: begin
        mul_a     = DATA_W'(x_r[CW-1:DATA_W]);
        mul_b     = INV_GAIN_Q32;
        state_nxt = ST_MAG2;
      end
      ST_MAG2: state_nxt = ST_EL0;
      ST_EL0: begin
        mul_a     = mag_r[DATA_W-1:0];
        mul_b     = scale_r;
        state_nxt = ST_EL1;
      end
      ST_EL1: begin
        mul_a     = DATA_W'(mag_r[MAG_W-1:DATA_W]);
        mul_b     = scale_r;
        state_nxt = ST_EL2;
      end
      ST_EL2: state_nxt = ST_PUT;
      ST_PUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      radius_r    <= RADIUS_RST;
      scale_r     <= SCALE_RST;
      launch_x_r  <= '0;
      launch_y_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LAUNCH_RADIUS: radius_r <= cfg_data;
          REG_ELONG_SCALE:   scale_r  <= cfg_data;
          default: ;
        endcase
      end
      if (launch_clr) begin
        launch_x_r <= '0;
        launch_y_r <= '0;
      end
      if (launch_wr_x) launch_x_r <= launch_val;
      if (launch_wr_y) launch_y_r <= launch_val;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (out_load) begin
      out_el_r  <= res_el_r;
      out_ang_r <= res_ang_r;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cx_r <= in_coord_x;
          cy_r <= in_coord_y;
        end
      end
      ST_SQY: acc_r <= prod_r;
      ST_SQSUM: begin
        acc_r <= acc_r + prod_r;
        rt_r  <= '0;
        bit_r <= SQRT_BIT0;
      end
      ST_SQRT: begin
        if (acc_r >= sqrt_trial) begin
          acc_r <= acc_r - sqrt_trial;
          rt_r  <= (rt_r >> 1) + bit_r;
        end else begin
          rt_r <= rt_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ST_OFS: begin
        step_r <= '0;
        if (dx == '0 && dy == '0) begin
          res_el_r  <= '0;
          res_ang_r <= '0;
        end
        if (dx[OFS_W-1]) begin
          x_r <= -x_ofs;
          y_r <= -y_ofs;
          z_r <= dy[OFS_W-1] ? -PI_Q28 : PI_Q28;
        end else begin
          x_r <= x_ofs;
          y_r <= y_ofs;
          z_r <= '0;
        end
      end
      ST_ROT: begin
        step_r <= step_r + 1'b1;
        if (!y_r[CW-1]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_v;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_v;
        end
      end
      ST_MAG1: acc_r <= prod_r;
      ST_MAG2: begin
        mag_r     <= hi_sum[MAG_W+GUARD-1:GUARD];
        res_ang_r <= z_clamp[ANGLE_W-1:0];
      end
      ST_EL1: acc_r <= prod_r;
      ST_EL2: begin
        if (|hi_sum[PROD_W-1:24]) begin
          res_el_r <= {DATA_W{1'b1}};
        end else begin
          res_el_r <= {hi_sum[23:0], acc_r[DATA_W-1:24]};
        end
      end
      default: ;
    endcase
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_elongation = out_el_r;
  assign out_angle      = out_ang_r;

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIVX_WAIT || state_r == ST_DIVY_WAIT))
    else $error("divider finished outside a wait state");

  a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAG0) |-> !x_r[CW-1])
    else $error("negative CORDIC magnitude");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ang_r <= PI_ANG && out_ang_r >= -PI_ANG))
    else $error("angle outside -pi..pi");

  a_put_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUT && out_free) |=> out_valid_r)
    else $error("result not presented");

endmodule

`default_nettype wire
